### rtl/mbr_pkg.sv
// shared constants for the multi-reader byte ring
`default_nettype none

package mbr_pkg;

  localparam int unsigned RING_DEPTH = 2048;
  localparam int unsigned READERS    = 8;
  localparam int unsigned MAX_BURST  = 64;

  localparam int unsigned CNT_W  = 32;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned RID_W  = 3;
  localparam int unsigned REQ_W  = 7;
  localparam int unsigned SLOT_W = $clog2(RING_DEPTH);
  localparam int unsigned RIDX_W = (READERS > 1) ? $clog2(READERS) : 1;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_OPEN  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

endpackage

`default_nettype wire

### rtl/mbr_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module mbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/multi_reader_byte_ring.sv
// Multi-reader byte ring: one byte ring shared by READERS readers, each with a
// private 32-bit read position. A write word (func 0) stores its byte at the
// running write count modulo RING_DEPTH and bumps the count; an open word
// (func 1) moves the reader's position to the write count; a read word
// (func 2) either reports an overrun (reader more than RING_DEPTH bytes
// behind, position snaps to the write count, one result word) or streams
// min(request, available) bytes, request saturated to MAX_BURST, with last
// on the final byte. Unused func code, reader out of range, zero request or
// nothing available give no result. Write and open words are taken in the
// idle state. A read word is accepted in idle and its available count is
// evaluated in the calc state; an overrun or an empty read ends there. A
// burst then reads one byte per cycle from the ring memory, drains the ram
// stage and returns to idle, and the next word is held off until then; the
// byte rate is set by the single read port of the ring memory. Output
// stalls slow the burst down without losing bytes. The ring memory has no
// reset and needs no clearing pass; reading a slot that was never written
// returns whatever it holds.
`default_nettype none

module multi_reader_byte_ring
  import mbr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [RID_W-1:0]  reader_id_i,
  input  wire logic [DATA_W-1:0] write_data_i,
  input  wire logic [REQ_W-1:0]  read_count_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [DATA_W-1:0]      read_data_o,
  output logic                   has_data_o,
  output logic                   overrun_o,
  output logic                   last_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CALC  = 3'b010,
    ST_BURST = 3'b100
  } state_e;

  // slot that follows a counter value; the slot restarts at zero when the
  // counter wraps so it always equals counter mod RING_DEPTH
  function automatic logic [SLOT_W-1:0] next_slot(logic [CNT_W-1:0]  cnt,
                                                  logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    if (cnt == '1) begin
      res = '0;
    end else if (slot == SLOT_W'(RING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = slot + 1'b1;
    end
    return res;
  endfunction

  state_e state_q, state_d;

  // write side
  logic [CNT_W-1:0]  wcnt_q;
  logic [SLOT_W-1:0] wslot_q;

  // per-reader position and its slot
  logic [CNT_W-1:0]  pos_q   [READERS];
  logic [SLOT_W-1:0] pslot_q [READERS];

  // burst context
  logic [RIDX_W-1:0] rid_q;
  logic [REQ_W-1:0]  req_q;
  logic [CNT_W-1:0]  cur_pos_q;
  logic [SLOT_W-1:0] cur_slot_q;
  logic [REQ_W-1:0]  remain_q;

  // ram read stage: rdata holds an unsent byte while rd_valid_q is set
  logic              rd_valid_q;
  logic              rd_last_q;
  logic [DATA_W-1:0] ram_rdata;

  // output word register
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_has_q;
  logic              out_ovr_q;
  logic              out_last_q;

  logic              accept;
  logic              rid_ok;
  logic [RIDX_W-1:0] rid_in;
  logic [REQ_W-1:0]  req_sat;
  logic              out_free;
  logic              move;
  logic              issue;
  logic [CNT_W-1:0]  avail;
  logic              ovr;
  logic [REQ_W-1:0]  take;
  logic [SLOT_W-1:0] cur_slot_nxt;
  logic              ovr_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign rid_ok     = (32'(reader_id_i) < 32'(READERS));
  assign rid_in     = RIDX_W'(reader_id_i);
  assign req_sat    = (read_count_i > REQ_W'(MAX_BURST)) ? REQ_W'(MAX_BURST) : read_count_i;

  assign out_free = !out_valid_q || out_ready_i;
  assign move     = rd_valid_q && out_free;
  assign issue    = (state_q == ST_BURST) && (remain_q != '0) && (!rd_valid_q || move);

  // evaluation of a read word
  assign avail    = wcnt_q - cur_pos_q;
  assign ovr      = (avail > CNT_W'(RING_DEPTH));
  assign take     = (avail < CNT_W'(req_q)) ? REQ_W'(avail) : req_q;
  assign ovr_load = (state_q == ST_CALC) && ovr && out_free;

  assign cur_slot_nxt = next_slot(cur_pos_q, cur_slot_q);

  mbr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept && (func_i == FUNC_WRITE)),
    .waddr_i (wslot_q),
    .wdata_i (write_data_i),
    .re_i    (issue),
    .raddr_i (cur_slot_q),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (func_i == FUNC_READ) && rid_ok && (read_count_i != '0)) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (ovr) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else if (take == '0) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_BURST;
        end
      end
      ST_BURST: begin
        // leave once every byte has left the ram stage
        if ((remain_q == '0) && !rd_valid_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // write count and its slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q  <= '0;
      wslot_q <= '0;
    end else if (accept && (func_i == FUNC_WRITE)) begin
      wcnt_q  <= wcnt_q + 1'b1;
      wslot_q <= next_slot(wcnt_q, wslot_q);
    end
  end

  // reader positions: open, overrun skip, end of burst
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < READERS; i++) begin
        pos_q[i]   <= '0;
        pslot_q[i] <= '0;
      end
    end else begin
      priority if (accept && (func_i == FUNC_OPEN) && rid_ok) begin
        pos_q[rid_in]   <= wcnt_q;
        pslot_q[rid_in] <= wslot_q;
      end else if (ovr_load) begin
        pos_q[rid_q]   <= wcnt_q;
        pslot_q[rid_q] <= wslot_q;
      end else if (issue && (remain_q == REQ_W'(1))) begin
        pos_q[rid_q]   <= cur_pos_q + 1'b1;
        pslot_q[rid_q] <= cur_slot_nxt;
      end
    end
  end

  // burst context
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
    end else if (state_q == ST_CALC) begin
      remain_q <= ovr ? '0 : take;
    end else if (issue) begin
      remain_q <= remain_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rid_q      <= rid_in;
      req_q      <= req_sat;
      cur_pos_q  <= pos_q[rid_in];
      cur_slot_q <= pslot_q[rid_in];
    end else if (issue) begin
      cur_pos_q  <= cur_pos_q + 1'b1;
      cur_slot_q <= cur_slot_nxt;
    end
  end

  // ram read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      rd_last_q  <= 1'b0;
    end else if (issue) begin
      rd_valid_q <= 1'b1;
      rd_last_q  <= (remain_q == REQ_W'(1));
    end else if (move) begin
      rd_valid_q <= 1'b0;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move || ovr_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (move) begin
      out_data_q <= ram_rdata;
      out_has_q  <= 1'b1;
      out_ovr_q  <= 1'b0;
      out_last_q <= rd_last_q;
    end else if (ovr_load) begin
      out_data_q <= '0;
      out_has_q  <= 1'b0;
      out_ovr_q  <= 1'b1;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign has_data_o  = out_has_q;
  assign overrun_o   = out_ovr_q;
  assign last_o      = out_last_q;

`ifndef ASSERT_OFF
  // the ram stage is empty whenever a new word can be taken
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rd_valid_q)
    else $error("ram stage busy while accepting words");

  // an overrun word carries no byte and closes its item
  a_ovr_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overrun_o) |-> (last_o && !has_data_o))
    else $error("malformed overrun word");

  // a byte in flight only exists during a burst
  a_rd_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> (state_q == ST_BURST))
    else $error("ram read outside a burst");

  // a drained burst returns to idle
  a_burst_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_BURST) && (remain_q == '0) && !rd_valid_q) |=> (state_q == ST_IDLE))
    else $error("burst did not finish");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the multi-reader byte ring: directed script, random traffic
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbr_pkg::*;

  // the one func code the block leaves unused
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam realtime CLK_PERIOD   = 10ns;
  localparam int      RESET_CYCLES = 6;
  // random words per idling phase
  localparam int      PHASE_WORDS  = 100;
  // a full burst plus accept, evaluate and drain cycles, with margin
  localparam int      DRAIN_CYCLES = MAX_BURST + 16;
  // full bursts only, under the heaviest backpressure, stay well under this limit
  localparam int      CYCLE_LIMIT  = 1_000_000;
  localparam int      PRINT_CAP    = 40;
  localparam int      SCRIPT_LEN   = 22;

  // one result word as the block emits it
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              has_data;
    logic              overrun;
    logic              last;
  } ring_word_t;

  // one row of the directed script; typed rows carry their own expectation
  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic [RID_W-1:0]  rid;
    logic [DATA_W-1:0] data;
    logic [REQ_W-1:0]  cnt;
    bit                typed;
    int unsigned       typed_n;
    logic [DATA_W-1:0] typed_data;
  } script_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [FUNC_W-1:0] func_i;
  logic [RID_W-1:0]  reader_id_i;
  logic [DATA_W-1:0] write_data_i;
  logic [REQ_W-1:0]  read_count_i;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [DATA_W-1:0] read_data_o;
  logic              has_data_o;
  logic              overrun_o;
  logic              last_o;

  // mirror of the block state
  logic [DATA_W-1:0] ring_mirror [RING_DEPTH];
  logic [CNT_W-1:0]  bytes_written;
  logic [CNT_W-1:0]  reader_pos [READERS];

  // result words still owed by the block, oldest first
  ring_word_t pending_bytes[$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // directed script, starting from reset: ring empty, all readers at zero
  script_row_t script_rows [SCRIPT_LEN] = '{
    // nothing written yet: a read gives nothing
    '{FUNC_READ,   3'd0, 8'h00, 7'd1,   1'b1, 0, 8'h00},
    // writes, with the ignored fields at their extremes
    '{FUNC_WRITE,  3'd0, 8'h00, 7'd0,   1'b0, 0, 8'h00},
    '{FUNC_WRITE,  3'd7, 8'hFF, 7'd127, 1'b0, 0, 8'h00},
    '{FUNC_WRITE,  3'd5, 8'hA5, 7'd64,  1'b0, 0, 8'h00},
    '{FUNC_WRITE,  3'd2, 8'h5A, 7'd1,   1'b0, 0, 8'h00},
    // zero request: no result and the position stays
    '{FUNC_READ,   3'd0, 8'h00, 7'd0,   1'b1, 0, 8'h00},
    // single byte: the oldest one
    '{FUNC_READ,   3'd0, 8'hFF, 7'd1,   1'b1, 1, 8'h00},
    // oversized request gets the remaining three
    '{FUNC_READ,   3'd0, 8'h00, 7'd127, 1'b0, 0, 8'h00},
    // caught up: nothing available
    '{FUNC_READ,   3'd0, 8'h00, 7'd64,  1'b1, 0, 8'h00},
    // unused func code is dropped
    '{FUNC_UNUSED, 3'd7, 8'hFF, 7'd127, 1'b1, 0, 8'h00},
    '{FUNC_OPEN,   3'd1, 8'h00, 7'd0,   1'b0, 0, 8'h00},
    // freshly opened reader sees nothing
    '{FUNC_READ,   3'd1, 8'h00, 7'd10,  1'b1, 0, 8'h00},
    '{FUNC_WRITE,  3'd3, 8'h81, 7'd0,   1'b0, 0, 8'h00},
    '{FUNC_WRITE,  3'd4, 8'h7E, 7'd0,   1'b0, 0, 8'h00},
    '{FUNC_READ,   3'd1, 8'h00, 7'd64,  1'b0, 0, 8'h00},
    // top reader id, split burst
    '{FUNC_READ,   3'd7, 8'h00, 7'd2,   1'b0, 0, 8'h00},
    '{FUNC_READ,   3'd7, 8'h00, 7'd64,  1'b0, 0, 8'h00},
    // request equal to what is available
    '{FUNC_READ,   3'd3, 8'h00, 7'd6,   1'b0, 0, 8'h00},
    '{FUNC_OPEN,   3'd0, 8'hFF, 7'd127, 1'b0, 0, 8'h00},
    '{FUNC_WRITE,  3'd6, 8'h3C, 7'd64,  1'b0, 0, 8'h00},
    '{FUNC_READ,   3'd0, 8'h00, 7'd1,   1'b1, 1, 8'h3C},
    '{FUNC_READ,   3'd6, 8'h00, 7'd64,  1'b0, 0, 8'h00}
  };

  multi_reader_byte_ring DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .reader_id_i  (reader_id_i),
    .write_data_i (write_data_i),
    .read_count_i (read_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .has_data_o   (has_data_o),
    .overrun_o    (overrun_o),
    .last_o       (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // receiver backpressure, changed only at the falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // applies one accepted word to the mirror and returns the result words it must produce
  function automatic void ring_step(input logic [FUNC_W-1:0] fn,
                                    input logic [RID_W-1:0] rid,
                                    input logic [DATA_W-1:0] data,
                                    input logic [REQ_W-1:0] cnt,
                                    output ring_word_t words[$]);
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] avail;
    logic [CNT_W-1:0] want;
    logic [CNT_W-1:0] take;
    ring_word_t       w;
    words.delete();
    if (fn == FUNC_WRITE) begin
      ring_mirror[bytes_written % RING_DEPTH] = data;
      bytes_written = bytes_written + 1;
      return;
    end
    if (fn == FUNC_UNUSED || rid >= READERS) return;
    if (fn == FUNC_OPEN) begin
      reader_pos[rid] = bytes_written;
      return;
    end
    // read burst; a zero request skips even the overrun check
    if (cnt == 0) return;
    want  = (cnt > MAX_BURST) ? MAX_BURST : cnt;
    pos   = reader_pos[rid];
    avail = bytes_written - pos;
    if (avail > RING_DEPTH) begin
      // lapped by the writer: skip ahead, one overrun word
      reader_pos[rid] = bytes_written;
      w = '{data: '0, has_data: 1'b0, overrun: 1'b1, last: 1'b1};
      words.push_back(w);
      return;
    end
    take = (avail < want) ? avail : want;
    for (int unsigned i = 0; i < take; i++) begin
      w = '{data: ring_mirror[(pos + i) % RING_DEPTH], has_data: 1'b1, overrun: 1'b0,
            last: (i + 1 == take)};
      words.push_back(w);
    end
    reader_pos[rid] = pos + take;
  endfunction

  // drives one input word; entered and left just after a falling edge
  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [RID_W-1:0] rid,
                           input logic [DATA_W-1:0] data, input logic [REQ_W-1:0] cnt,
                           input bit typed = 1'b0, input int unsigned typed_n = 0,
                           input logic [DATA_W-1:0] typed_data = '0);
    ring_word_t words[$];
    ring_word_t w;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= fn;
    reader_id_i  <= rid;
    write_data_i <= data;
    read_count_i <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    // accepted at this edge: mirror state moves in acceptance order
    ring_step(fn, rid, data, cnt, words);
    if (typed) begin
      words.delete();
      if (typed_n == 1) begin
        w = '{data: typed_data, has_data: 1'b1, overrun: 1'b0, last: 1'b1};
        words.push_back(w);
      end
    end
    foreach (words[i]) pending_bytes.push_back(words[i]);
    @(negedge clk_i);
  endtask

  // mostly writes and reads; reads favor short and full bursts, some zero or oversized
  task automatic random_word();
    logic [FUNC_W-1:0] fn;
    logic [REQ_W-1:0]  cnt;
    int unsigned       pick;
    int unsigned       spread;
    pick   = $urandom_range(99);
    spread = $urandom_range(99);
    if (pick < 52)      fn = FUNC_WRITE;
    else if (pick < 84) fn = FUNC_READ;
    else if (pick < 93) fn = FUNC_OPEN;
    else                fn = FUNC_UNUSED;
    if (spread < 5)       cnt = '0;
    else if (spread < 15) cnt = REQ_W'($urandom_range(127, MAX_BURST + 1));
    else if (spread < 30) cnt = REQ_W'($urandom_range(MAX_BURST, MAX_BURST - 8));
    else                  cnt = REQ_W'($urandom_range(16, 1));
    send_word(fn, RID_W'($urandom_range(7)), DATA_W'($urandom_range(255)), cnt);
  endtask

  // compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin : result_check
    ring_word_t exp_w;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected word data=%02h has=%b ovr=%b last=%b",
                                  read_data_o, has_data_o, overrun_o, last_o));
      end else begin
        exp_w = pending_bytes.pop_front();
        if (read_data_o !== exp_w.data)
          report_mismatch($sformatf("read_data %02h, want %02h", read_data_o, exp_w.data));
        if (has_data_o !== exp_w.has_data)
          report_mismatch($sformatf("has_data %b, want %b", has_data_o, exp_w.has_data));
        if (overrun_o !== exp_w.overrun)
          report_mismatch($sformatf("overrun %b, want %b", overrun_o, exp_w.overrun));
        if (last_o !== exp_w.last)
          report_mismatch($sformatf("last %b, want %b", last_o, exp_w.last));
      end
    end
  end

  initial begin : stimulus
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = FUNC_WRITE;
    reader_id_i  = '0;
    write_data_i = '0;
    read_count_i = '0;
    bytes_written = '0;
    foreach (reader_pos[i]) reader_pos[i] = '0;
    tx_idle_pct = 23;
    rx_idle_pct = 85;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script_rows[i])
      send_word(script_rows[i].fn, script_rows[i].rid, script_rows[i].data,
                script_rows[i].cnt, script_rows[i].typed, script_rows[i].typed_n,
                script_rows[i].typed_data);

    // sender idles lightly then heavily, receiver the other way, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 23;
          rx_idle_pct = 85;
        end
        1: begin
          tx_idle_pct = 85;
          rx_idle_pct = 23;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      repeat (PHASE_WORDS) random_word();
    end
    in_valid_i <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk_i);
    // a read that produces nothing may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/mbr_pkg.sv
rtl/mbr_ram.sv
rtl/multi_reader_byte_ring.sv
tb/tb_top.sv
